### hdl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, codes and the card type table for the card socket detect
// and status block.
// ----------------------------------------------------------------------------
package csd_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_POLL       = 2'd1,
    OP_SET_SOCKET = 2'd2
  } op_t;

  // voltage sense sequence phases
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_VS_FLOAT = 2'd1,
    PH_VS1_LOW  = 2'd2,
    PH_VS2_LOW  = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic CFG_EVENT_MASK   = 1'b0;
  localparam logic CFG_SETTLE_TICKS = 1'b1;

  localparam int EVENT_W  = 5;
  localparam int SETTLE_W = 10;
  localparam int KIND_W   = 6;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 16;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 10'd10;

  // card type flags
  localparam logic [KIND_W-1:0] KIND_PCCARD  = 6'h01;
  localparam logic [KIND_W-1:0] KIND_CARDBUS = 6'h02;
  localparam logic [KIND_W-1:0] KIND_5V      = 6'h04;
  localparam logic [KIND_W-1:0] KIND_3V      = 6'h08;
  localparam logic [KIND_W-1:0] KIND_XV      = 6'h10;
  localparam logic [KIND_W-1:0] KIND_YV      = 6'h20;

  typedef struct packed {
    phase_t               phase;
    logic [SETTLE_W-1:0]  settle_count;
    logic [5:0]           sense_bits;
    logic                 card_present;
    logic [KIND_W-1:0]    card_kind;
    logic [EVENT_W-1:0]   prev_status;
    logic                 reset_out;
    logic                 vs1_float;
    logic                 vs2_float;
    logic                 en_pcmcia;
    logic                 en_cardbus;
  } sock_state_t;

  typedef struct packed {
    logic                status_valid;
    logic [EVENT_W-1:0]  status;
    logic [EVENT_W-1:0]  events;
  } report_t;

  // sense bits: bit0 vs1, bit1 vs2 (both floated); bit2 cd1, bit3 cd2 (vs1 low);
  // bit4 cd1, bit5 cd2 (vs2 low)
  function automatic logic [KIND_W-1:0] kind_lookup(input logic [5:0] code);
    logic [KIND_W-1:0] k;
    case (code)
      6'd3:    k = KIND_PCCARD | KIND_5V;
      6'd2:    k = KIND_PCCARD | KIND_5V | KIND_3V;
      6'd0:    k = KIND_PCCARD | KIND_5V | KIND_3V | KIND_XV;
      6'd19:   k = KIND_CARDBUS | KIND_3V;
      6'd10:   k = KIND_CARDBUS | KIND_3V | KIND_XV;
      6'd33:   k = KIND_CARDBUS | KIND_3V | KIND_XV | KIND_YV;
      6'd1:    k = KIND_PCCARD | KIND_XV;
      6'd11:   k = KIND_CARDBUS | KIND_3V;
      6'd7:    k = KIND_CARDBUS | KIND_XV | KIND_YV;
      6'd35:   k = KIND_CARDBUS | KIND_YV;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### hdl/csd_step.sv
// ----------------------------------------------------------------------------
// csd_step
// Next-state and report logic for one socket item.
// ----------------------------------------------------------------------------
module csd_step
  import csd_pkg::*;
(
  input  sock_state_t          state,
  input  logic [1:0]           operation,
  input  logic                 cd1_level,
  input  logic                 cd2_level,
  input  logic                 vs1_level,
  input  logic                 vs2_level,
  input  logic                 ready_level,
  input  logic                 reset_request,
  input  logic [EVENT_W-1:0]   event_mask,
  input  logic [SETTLE_W-1:0]  settle_ticks,
  output sock_state_t          state_next,
  output report_t              report
);

  logic               do_report;
  logic [KIND_W-1:0]  kind_sel;
  logic               present_sel;
  logic [EVENT_W-1:0] status;
  logic [5:0]         bits_p3;

  assign bits_p3 = state.sense_bits | {cd2_level, cd1_level, 4'b0000};

  always_comb begin
    state_next = state;
    do_report  = 1'b0;
    case (op_t'(operation))
      OP_TICK: begin
        if (state.phase != PH_IDLE) begin
          if (state.settle_count < settle_ticks) begin
            state_next.settle_count = state.settle_count + 1'b1;
          end else begin
            state_next.settle_count = '0;
            case (state.phase)
              PH_VS_FLOAT: begin
                state_next.sense_bits = state.sense_bits | {4'b0000, vs2_level, vs1_level};
                state_next.vs1_float  = 1'b0;
                state_next.vs2_float  = 1'b1;
                state_next.phase      = PH_VS1_LOW;
              end
              PH_VS1_LOW: begin
                state_next.sense_bits = state.sense_bits | {2'b00, cd2_level, cd1_level, 2'b00};
                state_next.vs1_float  = 1'b1;
                state_next.vs2_float  = 1'b0;
                state_next.phase      = PH_VS2_LOW;
              end
              default: begin
                state_next.sense_bits   = bits_p3;
                state_next.card_kind    = kind_lookup(bits_p3);
                state_next.vs1_float    = 1'b0;
                state_next.vs2_float    = 1'b0;
                state_next.en_pcmcia    = |(kind_lookup(bits_p3) & KIND_PCCARD);
                state_next.en_cardbus   = ~|(kind_lookup(bits_p3) & KIND_PCCARD);
                state_next.phase        = PH_IDLE;
                state_next.card_present = 1'b1;
                do_report               = 1'b1;
              end
            endcase
          end
        end
      end
      OP_POLL: begin
        if (state.phase == PH_IDLE) begin
          // new insertion kicks off the sense sequence with both pins floated
          if (!cd1_level && !cd2_level && !state.card_present) begin
            state_next.phase        = PH_VS_FLOAT;
            state_next.settle_count = '0;
            state_next.sense_bits   = '0;
            state_next.vs1_float    = 1'b1;
            state_next.vs2_float    = 1'b1;
          end else begin
            state_next.card_present = !cd1_level && !cd2_level;
            do_report               = 1'b1;
          end
        end
      end
      OP_SET_SOCKET: begin
        state_next.reset_out = reset_request ^
                               (state.card_present & |(state.card_kind & KIND_CARDBUS));
      end
      default: begin
      end
    endcase
  end

  assign kind_sel    = state_next.card_kind;
  assign present_sel = state_next.card_present;
  assign status      = {ready_level, |(kind_sel & KIND_XV), |(kind_sel & KIND_3V),
                        |(kind_sel & KIND_CARDBUS), present_sel};

  always_comb begin
    report = '0;
    if (do_report) begin
      report.status_valid = 1'b1;
      report.status       = status;
      report.events       = (status ^ state.prev_status) & event_mask;
    end
  end

  // previous status tracks the last report only; not folded into state_next above
  // to keep the report path simple

endmodule

### hdl/card_socket_detect_and_status.sv
// ----------------------------------------------------------------------------
// card_socket_detect_and_status
// Card socket poller with voltage-sense card type detection.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: s_tuser carries the item kind (tick, status
// poll or set socket), s_tdata the sampled pin levels. Every accepted beat
// gives exactly one result beat on the m_ stream: m_tuser flags a completed
// status report, m_tdata holds the status, masked change events and the
// current VS drive, card reset and logic enable levels.
// Each item passes an input register and a result register, and one item is
// taken per cycle while m_tready is high; the state update for an item is
// combinational logic ahead of the state and result registers.
// When m_tready is low the result register holds; the input register still
// takes one more beat, after which s_tready drops until the result leaves.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 event
// mask, 1 settle ticks) at the clock edge, no wait states.
// Reset (rst, synchronous) empties both registers, sets the event mask to
// 0 and the settle ticks to 10, forgets any card and drives both VS pins
// low with both card logics disabled.
// ----------------------------------------------------------------------------
module card_socket_detect_and_status
  import csd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cd1_level, cd2_level, vs1_level, vs2_level, ready_level, reset_request, pad
  input  logic [IN_W-1:0]      s_tdata,
  // operation
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // detected, is_cardbus, supports_3v, supports_xv, card_ready, events[4:0],
  // vs1_float, vs2_float, card_reset, enable_pcmcia, enable_cardbus, pad
  output logic [OUT_W-1:0]     m_tdata,
  // status_valid
  output logic                 m_tuser,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SETTLE_W-1:0]  cfg_data
);

  logic [EVENT_W-1:0]  event_mask;
  logic [SETTLE_W-1:0] settle_ticks;

  logic                in_valid;
  logic [1:0]          in_op;
  logic [5:0]          in_pins;
  logic                advance;

  sock_state_t         state;
  sock_state_t         state_next;
  sock_state_t         state_upd;
  report_t             report;

  logic                out_valid;
  logic [OUT_W-1:0]    out_data;
  logic                out_user;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_mask   <= '0;
      settle_ticks <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EVENT_MASK:   event_mask   <= cfg_data[EVENT_W-1:0];
        CFG_SETTLE_TICKS: settle_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_pins <= s_tdata[5:0];
    end
  end

  csd_step u_step (
    .state         (state),
    .operation     (in_op),
    .cd1_level     (in_pins[0]),
    .cd2_level     (in_pins[1]),
    .vs1_level     (in_pins[2]),
    .vs2_level     (in_pins[3]),
    .ready_level   (in_pins[4]),
    .reset_request (in_pins[5]),
    .event_mask    (event_mask),
    .settle_ticks  (settle_ticks),
    .state_next    (state_next),
    .report        (report)
  );

  // last reported status is kept for change events
  always_comb begin
    state_upd = state_next;
    if (report.status_valid) begin
      state_upd.prev_status = report.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      state <= state_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_user <= report.status_valid;
      out_data <= {1'b0, state_next.en_cardbus, state_next.en_pcmcia,
                   state_next.reset_out, state_next.vs2_float, state_next.vs1_float,
                   report.events, report.status};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

endmodule
